// ----- hw/rtl/otbs_pkg.sv -----
package otbs_pkg;

    localparam int unsigned LEN_W      = 16;
    localparam int unsigned TRIM_W     = 8;
    localparam int unsigned STEP_W     = 7;
    localparam int unsigned DEV_W      = 14;

    localparam logic [LEN_W-1:0]  TARGET_RESET = 16'd2356;
    localparam logic [DEV_W-1:0]  DEV_INIT     = 14'd9999;
    localparam logic [STEP_W-1:0] FIRST_STEP   = 7'd64;
    localparam logic [TRIM_W-1:0] HIGH_BASE    = 8'd128;

    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_MEASURE = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [LEN_W-1:0] frame_length;
    } req_t;

    typedef struct packed {
        logic [TRIM_W-1:0] trim_value;
        logic              final_res;
    } res_t;

    typedef struct packed {
        logic              searching;
        logic [STEP_W-1:0] step_size;
    } status_t;

endpackage

// ----- hw/rtl/otbs_in_stage.sv -----
module otbs_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  otbs_pkg::req_t s_req,
    input  logic          advance,
    output logic          req_valid,
    output otbs_pkg::req_t req
);

    logic           valid_reg;
    logic           valid_next;
    otbs_pkg::req_t req_reg;

    assign s_ready   = !valid_reg || advance;
    assign req_valid = valid_reg;
    assign req       = req_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req;
        end
    end

endmodule

// ----- hw/rtl/otbs_search.sv -----
module otbs_search (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             fire,
    input  otbs_pkg::req_t                   req,
    input  logic [otbs_pkg::LEN_W-1:0]       target_length,
    output otbs_pkg::res_t                   res,
    output otbs_pkg::status_t                status
);

    logic                          searching_reg, searching_next;
    logic                          region_reg, region_next;
    logic [otbs_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [otbs_pkg::TRIM_W-1:0]   trial_reg, trial_next;
    logic [otbs_pkg::TRIM_W-1:0]   best_trim_reg, best_trim_next;
    logic [otbs_pkg::DEV_W-1:0]    best_dev_reg, best_dev_next;
    logic [otbs_pkg::LEN_W-1:0]    dev;
    logic                          below;
    logic [otbs_pkg::STEP_W-1:0]   half_step;

    assign below     = req.frame_length < target_length;
    assign dev       = below ? (target_length - req.frame_length)
                             : (req.frame_length - target_length);
    assign half_step = step_reg >> 1;

    assign status.searching = searching_reg;
    assign status.step_size = step_reg;

    always_comb begin
        searching_next = searching_reg;
        region_next    = region_reg;
        step_next      = step_reg;
        trial_next     = trial_reg;
        best_trim_next = best_trim_reg;
        best_dev_next  = best_dev_reg;
        res.trim_value = best_trim_reg;
        res.final_res  = 1'b1;
        if (req.kind == otbs_pkg::KIND_START) begin
            searching_next = 1'b1;
            region_next    = 1'b0;
            step_next      = otbs_pkg::FIRST_STEP;
            best_trim_next = '0;
            best_dev_next  = otbs_pkg::DEV_INIT;
            trial_next     = {1'b0, otbs_pkg::FIRST_STEP};
            res.trim_value = {1'b0, otbs_pkg::FIRST_STEP};
            res.final_res  = 1'b0;
        end else if (searching_reg) begin
            // best_dev never exceeds the initial 9999, so widening it is exact
            if (dev < {{(otbs_pkg::LEN_W-otbs_pkg::DEV_W){1'b0}}, best_dev_reg}) begin
                best_trim_next = trial_reg;
                best_dev_next  = dev[otbs_pkg::DEV_W-1:0];
            end
            if (half_step == '0) begin
                step_next = otbs_pkg::FIRST_STEP;
                if (!region_reg) begin
                    region_next    = 1'b1;
                    trial_next     = otbs_pkg::HIGH_BASE | {1'b0, otbs_pkg::FIRST_STEP};
                    res.trim_value = otbs_pkg::HIGH_BASE | {1'b0, otbs_pkg::FIRST_STEP};
                    res.final_res  = 1'b0;
                end else begin
                    searching_next = 1'b0;
                    res.trim_value = best_trim_next;
                    res.final_res  = 1'b1;
                end
            end else begin
                step_next = half_step;
                if (below) begin
                    trial_next = trial_reg + {1'b0, half_step};
                end else begin
                    trial_next = trial_reg - {1'b0, half_step};
                end
                res.trim_value = trial_next;
                res.final_res  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            searching_reg <= 1'b0;
            region_reg    <= 1'b0;
            step_reg      <= otbs_pkg::FIRST_STEP;
            trial_reg     <= '0;
            best_trim_reg <= '0;
            best_dev_reg  <= otbs_pkg::DEV_INIT;
        end else if (fire) begin
            searching_reg <= searching_next;
            region_reg    <= region_next;
            step_reg      <= step_next;
            trial_reg     <= trial_next;
            best_trim_reg <= best_trim_next;
            best_dev_reg  <= best_dev_next;
        end
    end

endmodule

// ----- hw/rtl/otbs_out_stage.sv -----
module otbs_out_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           req_valid,
    input  otbs_pkg::res_t res,
    output logic           advance,
    output logic           m_valid,
    input  logic           m_ready,
    output otbs_pkg::res_t m_res
);

    logic           valid_reg;
    logic           valid_next;
    otbs_pkg::res_t res_reg;

    assign advance = req_valid && (!valid_reg || m_ready);
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (!valid_reg || m_ready) begin
            valid_next = req_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

endmodule

// ----- hw/rtl/oscillator_trim_binary_search_top.sv -----
// Successive-approximation oscillator trim search. A start request (kind 0)
// returns the first trial trim; each measurement request (kind 1) carrying the
// frame length seen for the last trim returns the next trial, and after fourteen
// measurements the best trim flagged final. Measurements while idle return the
// best trim again, flagged final. Exactly one result per request. One request is
// taken every cycle while the result register is free or being read; each request
// passes an input register and then the result register, with the search state
// updated as its result is registered. target_length must be written while idle.
module oscillator_trim_binary_search_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [otbs_pkg::LEN_W-1:0]        cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [otbs_pkg::LEN_W-1:0]        s_frame_length,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [otbs_pkg::TRIM_W-1:0]       m_trim_value,
    output logic                              m_final_res
);

    logic [otbs_pkg::LEN_W-1:0] target_reg;
    otbs_pkg::req_t             s_req;
    otbs_pkg::req_t             req;
    otbs_pkg::res_t             res;
    otbs_pkg::res_t             m_res;
    otbs_pkg::status_t          status;
    logic                       req_valid;
    logic                       advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= otbs_pkg::TARGET_RESET;
        end else if (cfg_wr_en) begin
            target_reg <= cfg_wr_data;
        end
    end

    assign s_req.kind         = s_kind;
    assign s_req.frame_length = s_frame_length;

    otbs_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .advance   (advance),
        .req_valid (req_valid),
        .req       (req)
    );

    otbs_search u_search (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (advance),
        .req           (req),
        .target_length (target_reg),
        .res           (res),
        .status        (status)
    );

    otbs_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (req_valid),
        .res       (res),
        .advance   (advance),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_trim_value = m_res.trim_value;
    assign m_final_res  = m_res.final_res;

    // a held request always moves on once the result register is free
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        req_valid && !m_valid |-> advance)
        else $error("held request not advanced into free result register");

    // a final result closes the search
    a_final_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.final_res |=> !status.searching)
        else $error("search still running after final result");

    // step size is always a single power of two
    a_step_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(status.step_size))
        else $error("step size not a power of two");

    // a start request always yields a non-final trial
    a_start_trial: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && req.kind == otbs_pkg::KIND_START |=> m_valid && !m_final_res)
        else $error("start request did not give a trial trim");

endmodule

// ----- tb/otbs_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels, tracks the trim search alongside the block and
// compares every result with the trim it should carry.
module otbs_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [otbs_pkg::LEN_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_kind,
    input  logic [otbs_pkg::LEN_W-1:0]    s_frame_length,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [otbs_pkg::TRIM_W-1:0]   m_trim_value,
    input  logic                          m_final_res,
    output int                            errors,
    output int                            pending,
    output int                            taken
);

    logic [otbs_pkg::LEN_W-1:0]  target_len;
    logic                        hunting;
    logic                        upper_half;
    logic [otbs_pkg::STEP_W-1:0] stride;
    logic [otbs_pkg::TRIM_W-1:0] probe_trim;
    logic [otbs_pkg::TRIM_W-1:0] kept_trim;
    logic [otbs_pkg::DEV_W-1:0]  kept_dev;
    otbs_pkg::res_t              trims_due[$];

    function automatic void next_trim(input otbs_pkg::req_t rq);
        logic [otbs_pkg::LEN_W:0] dev;
        otbs_pkg::res_t           r;
        if (rq.kind == otbs_pkg::KIND_START) begin
            hunting    = 1'b1;
            upper_half = 1'b0;
            stride     = otbs_pkg::FIRST_STEP;
            kept_trim  = '0;
            kept_dev   = otbs_pkg::DEV_INIT;
            probe_trim = otbs_pkg::TRIM_W'(otbs_pkg::FIRST_STEP);
            r = '{probe_trim, 1'b0};
        end else if (!hunting) begin
            r = '{kept_trim, 1'b1};
        end else begin
            // true absolute difference, 17 bits wide
            if (rq.frame_length >= target_len)
                dev = {1'b0, rq.frame_length} - {1'b0, target_len};
            else
                dev = {1'b0, target_len} - {1'b0, rq.frame_length};
            if (dev < {3'b000, kept_dev}) begin
                kept_trim = probe_trim;
                kept_dev  = dev[otbs_pkg::DEV_W-1:0];
            end
            stride = stride >> 1;
            if (stride == '0) begin
                stride = otbs_pkg::FIRST_STEP;
                if (!upper_half) begin
                    upper_half = 1'b1;
                    probe_trim = otbs_pkg::HIGH_BASE
                                 + otbs_pkg::TRIM_W'(otbs_pkg::FIRST_STEP);
                    r = '{probe_trim, 1'b0};
                end else begin
                    hunting = 1'b0;
                    r = '{kept_trim, 1'b1};
                end
            end else begin
                if (rq.frame_length < target_len)
                    probe_trim = probe_trim + otbs_pkg::TRIM_W'(stride);
                else
                    probe_trim = probe_trim - otbs_pkg::TRIM_W'(stride);
                r = '{probe_trim, 1'b0};
            end
        end
        trims_due.push_back(r);
    endfunction

    always @(posedge aclk) begin
        otbs_pkg::res_t want;
        if (!aresetn) begin
            target_len = otbs_pkg::TARGET_RESET;
            hunting    = 1'b0;
            upper_half = 1'b0;
            stride     = otbs_pkg::FIRST_STEP;
            probe_trim = '0;
            kept_trim  = '0;
            kept_dev   = otbs_pkg::DEV_INIT;
            trims_due.delete();
            errors     = 0;
            taken      = 0;
        end else begin
            if (cfg_wr_en)
                target_len = cfg_wr_data;
            // results first, so a request taken on the same edge cannot mask a stray one
            if (m_valid && m_ready) begin
                if (trims_due.size() == 0) begin
                    $display("%0t: result trim %0d final %0d with nothing expected",
                             $time, m_trim_value, m_final_res);
                    errors++;
                end else begin
                    want = trims_due.pop_front();
                    if (m_trim_value !== want.trim_value) begin
                        $display("%0t: trim_value expected %0d got %0d",
                                 $time, want.trim_value, m_trim_value);
                        errors++;
                    end
                    if (m_final_res !== want.final_res) begin
                        $display("%0t: final_res expected %0d got %0d",
                                 $time, want.final_res, m_final_res);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                next_trim('{s_kind, s_frame_length});
                taken++;
            end
        end
        pending = trims_due.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int QUIET_LIMIT = 2000;
    localparam int TOTAL_REQS  = 1950;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_wr_en = 1'b0;
    logic [otbs_pkg::LEN_W-1:0]  cfg_wr_data = '0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic                        s_kind = otbs_pkg::KIND_START;
    logic [otbs_pkg::LEN_W-1:0]  s_frame_length = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [otbs_pkg::TRIM_W-1:0] m_trim_value;
    logic                        m_final_res;

    int errors, pending, taken;
    int sent = 0;
    int quiet = 0;
    int stall_left = 0;
    bit calm = 1'b0;
    logic [otbs_pkg::LEN_W-1:0] cur_target = otbs_pkg::TARGET_RESET;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    oscillator_trim_binary_search_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_frame_length (s_frame_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_trim_value   (m_trim_value),
        .m_final_res    (m_final_res)
    );

    otbs_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_frame_length (s_frame_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_trim_value   (m_trim_value),
        .m_final_res    (m_final_res),
        .errors         (errors),
        .pending        (pending),
        .taken          (taken)
    );

    // mostly no gap, some short, the odd long one
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // frame length clustered round the target, with extremes and noise
    function automatic logic [otbs_pkg::LEN_W-1:0] pick_len();
        int v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = 65535;
            2: v = cur_target;
            3, 4, 5, 6: v = int'(cur_target) + $urandom_range(0, 600) - 300;
            7, 8: v = int'(cur_target) + $urandom_range(0, 40000) - 20000;
            default: v = $urandom_range(0, 65535);
        endcase
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return otbs_pkg::LEN_W'(v);
    endfunction

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet == QUIET_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    task automatic send(input logic kind, input logic [otbs_pkg::LEN_W-1:0] len);
        int gap;
        int seen;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_frame_length <= len;
        seen = taken;
        do @(negedge aclk); while (taken == seen);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic write_target(input logic [otbs_pkg::LEN_W-1:0] v);
        drain();
        repeat (3) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        cur_target   = v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_sequence();
        int r;
        int n;
        calm = ($urandom_range(0, 7) == 0);
        r = $urandom_range(0, 19);
        if (r < 15) begin
            // full search, sometimes followed by measurements after the final trim
            send(otbs_pkg::KIND_START, otbs_pkg::LEN_W'($urandom));
            n = (r == 0) ? 14 + $urandom_range(1, 3) : 14;
            repeat (n) send(otbs_pkg::KIND_MEASURE, pick_len());
        end else if (r < 17) begin
            // cut short; the next start restarts it
            send(otbs_pkg::KIND_START, otbs_pkg::LEN_W'($urandom));
            repeat ($urandom_range(1, 13)) send(otbs_pkg::KIND_MEASURE, pick_len());
        end else begin
            repeat ($urandom_range(1, 6))
                send(logic'($urandom_range(0, 1)), otbs_pkg::LEN_W'($urandom));
        end
        if ($urandom_range(0, 9) == 0)
            drain();
    endtask

    initial begin
        logic [otbs_pkg::LEN_W-1:0] targets [7];
        targets = '{otbs_pkg::TARGET_RESET, 16'd0, 16'hFFFF, 16'd1,
                    otbs_pkg::LEN_W'($urandom), 16'd9999, 16'hFFFE};

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // measurement while idle straight after reset
        send(otbs_pkg::KIND_MEASURE, 16'hFFFF);
        // whole search with nothing ever inside the deviation window
        send(otbs_pkg::KIND_START, 16'h0000);
        repeat (14) send(otbs_pkg::KIND_MEASURE, 16'hFFFF);
        send(otbs_pkg::KIND_MEASURE, 16'h0000);
        // exact hit, then a restart part way through
        send(otbs_pkg::KIND_START, 16'hFFFF);
        send(otbs_pkg::KIND_MEASURE, otbs_pkg::TARGET_RESET);
        send(otbs_pkg::KIND_MEASURE, 16'h0000);
        send(otbs_pkg::KIND_START, 16'h0000);
        send(otbs_pkg::KIND_MEASURE, otbs_pkg::TARGET_RESET + 16'd1);
        send(otbs_pkg::KIND_MEASURE, 16'd1);

        for (int ph = 0; ph < 7; ph++) begin
            if (ph > 0)
                write_target(targets[ph]);
            while (sent < 25 + (ph + 1) * (TOTAL_REQS - 25) / 7)
                run_sequence();
        end

        calm = 1'b0;
        drain();
        repeat (10) @(negedge aclk);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/otbs_pkg.sv
hw/rtl/otbs_in_stage.sv
hw/rtl/otbs_search.sv
hw/rtl/otbs_out_stage.sv
hw/rtl/oscillator_trim_binary_search_top.sv
tb/otbs_checker.sv
tb/tb_top.sv
